>>> rtl/core/feg_pkg.sv
`timescale 1ns / 1ps

package feg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HOP_W    = 13;
  localparam int CHCNT_W  = 2;
  localparam int MAG_W    = 17;
  localparam int ENERGY_W = 33;
  localparam int SUM_W    = 44;
  localparam int TOTAL_W  = SUM_W + 1;
  localparam int RATIO_W  = 17;
  localparam int QSTEP_W  = 5;

  localparam int HOP_REG_MAX = 8191;
  localparam int CARRIED_CH  = 2;
  localparam int CHANNELS    = 2;

  localparam logic [SUM_W-1:0]   SUM_LIMIT = {SUM_W{1'b1}};
  localparam logic [RATIO_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [RATIO_W-1:0] HALF_Q16  = 17'd32768;
  localparam logic [QSTEP_W-1:0] FRAC_STEPS = 5'd16;

  localparam logic [HOP_W-1:0]   HOP_RESET = 13'd512;
  localparam logic [CHCNT_W-1:0] CH_RESET  = 2'd2;

  localparam logic [1:0] CFG_HOP_SIZE    = 2'd0;
  localparam logic [1:0] CFG_HARMONIC_CH = 2'd1;
  localparam logic [1:0] CFG_NOISE_CH    = 2'd2;

  typedef struct packed {
    logic valid;
    logic clear;
    logic close;
    logic last;
  } feg_stage_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CALC,
    DIV_HOLD
  } feg_div_state_t;

  function automatic logic [CHCNT_W-1:0] feg_eff_ch(input logic [CHCNT_W-1:0] cnt);
    logic [CHCNT_W-1:0] c;
    c = cnt;
    if (int'(c) > CARRIED_CH) c = CHCNT_W'(CARRIED_CH);
    if (int'(c) > CHANNELS) c = CHCNT_W'(CHANNELS);
    return c;
  endfunction

endpackage

>>> rtl/core/feg_lane.sv
`timescale 1ns / 1ps

module feg_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]   ch0,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]   ch1,
  input  logic        [feg_pkg::CHCNT_W-1:0]    chan_cnt,
  input  feg_pkg::feg_stage_t                   stage,
  output logic        [feg_pkg::SUM_W-1:0]      sum_new
);
  import feg_pkg::*;

  logic [CHCNT_W-1:0]  eff;
  logic signed [MAG_W-1:0] a_ext;
  logic signed [MAG_W-1:0] pair;
  logic [MAG_W-1:0]    abs_a;
  logic [MAG_W-1:0]    abs_pair;
  logic [MAG_W-1:0]    mag;
  logic [ENERGY_W-1:0] energy_nxt;
  logic [ENERGY_W-1:0] energy_r;
  logic [TOTAL_W-1:0]  sum_add;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;

  // One enabled channel counts twice its magnitude, so both cases square the same way.
  always_comb begin
    eff      = feg_eff_ch(chan_cnt);
    a_ext    = MAG_W'(ch0);
    pair     = MAG_W'(ch0) + MAG_W'(ch1);
    abs_a    = a_ext[MAG_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
    abs_pair = pair[MAG_W-1] ? MAG_W'(-pair) : MAG_W'(pair);
    case (eff)
      2'd1:    mag = {abs_a[MAG_W-2:0], 1'b0};
      2'd2:    mag = abs_pair;
      default: mag = '0;
    endcase
    energy_nxt = ENERGY_W'(mag * mag);
  end

  always_comb begin
    sum_add = {1'b0, sum_r} + TOTAL_W'(energy_r);
    sum_new = (sum_add > TOTAL_W'(SUM_LIMIT)) ? SUM_LIMIT : sum_add[SUM_W-1:0];
    sum_nxt = sum_r;
    if (stage.valid) begin
      sum_nxt = (stage.clear || stage.close) ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      energy_r <= energy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

>>> rtl/core/feg_div.sv
`timescale 1ns / 1ps

module feg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [feg_pkg::SUM_W-1:0]       h_sum,
  input  logic [feg_pkg::SUM_W-1:0]       n_sum,
  input  logic                            last,
  output logic                            busy,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [feg_pkg::RATIO_W-1:0]     out_harmonic_ratio,
  output logic [feg_pkg::RATIO_W-1:0]     out_noise_ratio,
  output logic                            out_final_frame
);
  import feg_pkg::*;

  feg_div_state_t state_r;
  feg_div_state_t state_nxt;

  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  total_nxt;
  logic [TOTAL_W-1:0]  rem_r;
  logic [TOTAL_W-1:0]  rem_nxt;
  logic [TOTAL_W:0]    rem_dbl;
  logic                q_bit;
  logic [RATIO_W-1:0]  q_r;
  logic [RATIO_W-1:0]  q_nxt;
  logic [QSTEP_W-1:0]  step_r;
  logic [QSTEP_W-1:0]  step_nxt;
  logic                last_r;
  logic                last_nxt;
  logic                out_free;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [RATIO_W-1:0]  h_ratio_r;
  logic [RATIO_W-1:0]  n_ratio_r;
  logic                final_r;
  logic                out_load;

  assign total    = {1'b0, h_sum} + {1'b0, n_sum};
  assign rem_dbl  = {rem_r, 1'b0};
  assign q_bit    = rem_dbl >= {1'b0, total_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          state_nxt = (total == '0) ? DIV_HOLD : DIV_CALC;
        end
      end
      DIV_CALC: begin
        if (step_r == FRAC_STEPS - 1'b1) state_nxt = DIV_HOLD;
      end
      DIV_HOLD: begin
        if (out_free) state_nxt = DIV_IDLE;
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  // The quotient never exceeds one, so the integer bit comes from a single compare at start.
  always_comb begin
    total_nxt = total_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    out_load  = 1'b0;
    busy      = (state_r != DIV_IDLE);
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          total_nxt = total;
          last_nxt  = last;
          step_nxt  = '0;
          if (total == '0) begin
            q_nxt   = HALF_Q16;
            rem_nxt = '0;
          end else if ({1'b0, h_sum} >= total) begin
            q_nxt   = RATIO_W'(1);
            rem_nxt = {1'b0, h_sum} - total;
          end else begin
            q_nxt   = '0;
            rem_nxt = {1'b0, h_sum};
          end
        end
      end
      DIV_CALC: begin
        rem_nxt  = q_bit ? TOTAL_W'(rem_dbl - {1'b0, total_r}) : rem_dbl[TOTAL_W-1:0];
        q_nxt    = {q_r[RATIO_W-2:0], q_bit};
        step_nxt = step_r + 1'b1;
      end
      DIV_HOLD: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DIV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    step_r  <= step_nxt;
    last_r  <= last_nxt;
    if (out_load) begin
      h_ratio_r <= q_r;
      n_ratio_r <= ONE_Q16 - q_r;
      final_r   <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_harmonic_ratio = h_ratio_r;
  assign out_noise_ratio    = n_ratio_r;
  assign out_final_frame    = final_r;

endmodule

>>> rtl/core/frame_energy_ratio_mask.sv
`timescale 1ns / 1ps

// Per-frame harmonic energy share. Each transfer carries one sample instant of two
// harmonic and two noise channels; a harmonic lane and a noise lane square the
// channel sum (one channel doubled) and accumulate it, so samples inside a frame are
// taken one per cycle. A sample that closes a frame (hop reached or end of buffer)
// hands both sums to a shared restoring divider that produces one quotient bit per
// cycle, and the input stalls until that divider has placed the ratio in the output
// register. A result waits there without holding up samples, but the next frame
// close keeps the input stalled until it has been taken.
module frame_energy_ratio_mask #(
  parameter int MAX_HOP = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [1:0]                           cfg_index,
  input  logic [feg_pkg::HOP_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]  in_harmonic_ch0,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]  in_harmonic_ch1,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]  in_noise_ch0,
  input  logic signed [feg_pkg::SAMPLE_W-1:0]  in_noise_ch1,
  input  logic                                 in_end_of_buffer,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [feg_pkg::RATIO_W-1:0]          out_harmonic_ratio,
  output logic [feg_pkg::RATIO_W-1:0]          out_noise_ratio,
  output logic                                 out_final_frame
);
  import feg_pkg::*;

  localparam int HOP_LIM = (MAX_HOP < HOP_REG_MAX) ? MAX_HOP : HOP_REG_MAX;
  localparam int FILL_W  = $clog2(HOP_LIM + 1);

  logic [HOP_W-1:0]   hop_r;
  logic [CHCNT_W-1:0] harm_ch_r;
  logic [CHCNT_W-1:0] noise_ch_r;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_nxt;
  logic [FILL_W-1:0]  hop_eff;
  logic [FILL_W:0]    fill_inc;
  logic               hop_zero;
  logic               accept;
  logic               closes;
  feg_stage_t         s1_r;
  feg_stage_t         s1_nxt;
  logic [SUM_W-1:0]   h_new;
  logic [SUM_W-1:0]   n_new;
  logic               div_busy;

  assign accept   = in_valid && !in_stall;
  assign in_stall = div_busy || (s1_r.valid && s1_r.close);
  assign hop_zero = (hop_r == '0);
  assign hop_eff  = (int'(hop_r) > HOP_LIM) ? FILL_W'(HOP_LIM) : FILL_W'(hop_r);
  assign fill_inc = {1'b0, fill_r} + 1'b1;
  assign closes   = (fill_inc >= {1'b0, hop_eff}) || in_end_of_buffer;

  always_comb begin
    fill_nxt = fill_r;
    s1_nxt   = '0;
    if (accept) begin
      s1_nxt.valid = 1'b1;
      s1_nxt.last  = in_end_of_buffer;
      if (hop_zero) begin
        s1_nxt.clear = 1'b1;
        fill_nxt     = '0;
      end else if (closes) begin
        s1_nxt.close = 1'b1;
        fill_nxt     = '0;
      end else begin
        fill_nxt = fill_inc[FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r      <= HOP_RESET;
      harm_ch_r  <= CH_RESET;
      noise_ch_r <= CH_RESET;
      fill_r     <= '0;
      s1_r       <= '0;
    end else begin
      fill_r <= fill_nxt;
      s1_r   <= s1_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_HOP_SIZE:    hop_r      <= cfg_data;
          CFG_HARMONIC_CH: harm_ch_r  <= cfg_data[CHCNT_W-1:0];
          CFG_NOISE_CH:    noise_ch_r <= cfg_data[CHCNT_W-1:0];
          default:         hop_r      <= hop_r;
        endcase
      end
    end
  end

  feg_lane u_harm_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .ch0      (in_harmonic_ch0),
    .ch1      (in_harmonic_ch1),
    .chan_cnt (harm_ch_r),
    .stage    (s1_r),
    .sum_new  (h_new)
  );

  feg_lane u_noise_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .ch0      (in_noise_ch0),
    .ch1      (in_noise_ch1),
    .chan_cnt (noise_ch_r),
    .stage    (s1_r),
    .sum_new  (n_new)
  );

  feg_div u_div (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (s1_r.valid && s1_r.close),
    .h_sum              (h_new),
    .n_sum              (n_new),
    .last               (s1_r.last),
    .busy               (div_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_harmonic_ratio (out_harmonic_ratio),
    .out_noise_ratio    (out_noise_ratio),
    .out_final_frame    (out_final_frame)
  );

endmodule
